// File: rtl/core/fcrm_pkg.sv
package fcrm_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 512;
  localparam int unsigned SECTOR_BYTES_DEF  = 512;
  localparam int unsigned MAX_RESULTS       = 64;
  localparam int unsigned NCNT_W            = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] CHAIN_END = 16'hffff;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SKIP_TEST,
    S_SKIP_CHK,
    S_SEG_CALC,
    S_LINK_CHK,
    S_EMIT,
    S_ERR
  } state_e;

endpackage

// File: rtl/core/fcrm_intf.sv
interface fcrm_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [8:0]  entry_index;
  logic [15:0] entry_value;
  logic [15:0] first_sector;
  logic [18:0] file_size;
  logic [17:0] read_offset;
  logic [14:0] read_length;

  modport source (
    output valid, cmd, entry_index, entry_value, first_sector, file_size,
           read_offset, read_length,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, entry_value, first_sector, file_size,
           read_offset, read_length,
    output ready
  );
endinterface

interface fcrm_seg_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] sector_addr;
  logic [8:0]  byte_start;
  logic [9:0]  byte_count;
  logic        last;

  modport source (
    output valid, status, sector_addr, byte_start, byte_count, last,
    input  ready
  );
  modport sink (
    input  valid, status, sector_addr, byte_start, byte_count, last,
    output ready
  );
endinterface

// File: rtl/core/fat_chain_read_mapper_unit.sv
// Maps read requests on a file onto disk sector segments by following a
// table of next-sector links held in an internal memory.
// The request channel carries two kinds of requests. A load request writes
// one link into the table and leaves the request channel ready. A read request walks
// the chain from the file's first sector, skipping whole sectors of the
// offset, and then emits one segment per sector touched on the segment
// channel, with last set on the final one. An empty file or a chain that
// ends during the skip gives a single error segment.
// The walk uses one subtract and compare on the remaining offset and one
// memory read port: each skipped sector passes through the skip test and
// skip check states, and each emitted segment through the segment calc,
// link check and emit states, the emit state waiting for the receiver.
// The request channel is ready only while no read request is in progress.
// A segment waits in the output register while the receiver stalls, and the
// walk holds until it is taken; the last segment may still wait while the
// next request is accepted. Reset clears the control state and the base
// register; the link table holds no defined value until it is loaded.
// The base register may be written only while the block is idle.
module fat_chain_read_mapper_unit
  import fcrm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned SECTOR_BYTES  = SECTOR_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  fcrm_req_if.sink          req_i,
  fcrm_seg_if.source        seg_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SW = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;
  localparam int unsigned CW = $clog2(SECTOR_BYTES + 1);

  state_e state_q, state_d;

  logic [31:0]       base_q;
  logic [15:0]       idx_q;
  logic [17:0]       rem_q;
  logic [14:0]       len_q;
  logic [18:0]       fsize_q;
  logic [14:0]       done_q;
  logic [NCNT_W-1:0] n_q;
  logic              first_q;
  logic              last_q;
  logic [31:0]       p_lba_q;
  logic [SW-1:0]     p_start_q;
  logic [CW-1:0]     p_count_q;
  logic [15:0]       rd_q;
  logic              rd_ok_q;

  logic              seg_valid_q;
  logic              seg_status_q;
  logic [31:0]       seg_lba_q;
  logic [8:0]        seg_start_q;
  logic [9:0]        seg_count_q;
  logic              seg_last_q;

  logic [15:0] mem [TABLE_ENTRIES];

  logic        req_acc;
  logic        out_free;
  logic        out_load;
  logic [15:0] nxt;
  logic        skip_more;
  logic        cont;
  logic [16:0] idx_ext;
  logic [16:0] eidx_ext;
  logic [SW-1:0] start_w;
  logic [15:0] rem_len;
  logic [15:0] avail;
  logic [15:0] count16;
  logic [31:0] start32;
  logic [31:0] count32;

  assign req_acc  = req_i.valid && req_i.ready;
  assign out_free = !seg_valid_q || seg_o.ready;
  assign nxt      = rd_ok_q ? rd_q : CHAIN_END;
  assign skip_more = rem_q >= 18'(SECTOR_BYTES);
  assign cont     = (done_q < len_q) && (19'(done_q) < fsize_q) &&
                    (n_q < NCNT_W'(MAX_RESULTS));
  assign idx_ext  = {1'b0, idx_q};
  assign eidx_ext = 17'(req_i.entry_index);

  assign start_w  = first_q ? SW'(rem_q) : '0;
  assign rem_len  = 16'(len_q) - 16'(done_q);
  assign avail    = 16'(SECTOR_BYTES) - 16'(start_w);
  assign count16  = (rem_len < avail) ? rem_len : avail;
  assign start32  = 32'(p_start_q);
  assign count32  = 32'(p_count_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_acc && req_i.cmd == CMD_READ) begin
          state_d = (req_i.first_sector == CHAIN_END) ? S_ERR : S_SKIP_TEST;
        end
      end
      S_SKIP_TEST: state_d = skip_more ? S_SKIP_CHK : S_SEG_CALC;
      S_SKIP_CHK:  state_d = (nxt == CHAIN_END) ? S_ERR : S_SKIP_TEST;
      S_SEG_CALC:  state_d = S_LINK_CHK;
      S_LINK_CHK:  state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = last_q ? S_IDLE : S_SEG_CALC;
        end
      end
      S_ERR: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = (state_q == S_IDLE);
    out_load    = ((state_q == S_EMIT) || (state_q == S_ERR)) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.cmd == CMD_LOAD && eidx_ext < 17'(TABLE_ENTRIES)) begin
      mem[eidx_ext[AW-1:0]] <= req_i.entry_value;
    end
    rd_q    <= mem[idx_ext[AW-1:0]];
    rd_ok_q <= idx_ext < 17'(TABLE_ENTRIES);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          idx_q   <= req_i.first_sector;
          rem_q   <= req_i.read_offset;
          len_q   <= req_i.read_length;
          fsize_q <= req_i.file_size;
          done_q  <= '0;
          n_q     <= '0;
          first_q <= 1'b1;
        end
      end
      S_SKIP_TEST: begin
        if (skip_more) begin
          rem_q <= rem_q - 18'(SECTOR_BYTES);
        end
      end
      S_SKIP_CHK: begin
        idx_q <= nxt;
      end
      S_SEG_CALC: begin
        p_lba_q   <= base_q + 32'(idx_q);
        p_start_q <= start_w;
        p_count_q <= CW'(count16);
        done_q    <= done_q + 15'(count16);
        n_q       <= n_q + 1'b1;
        first_q   <= 1'b0;
      end
      S_LINK_CHK: begin
        last_q <= !cont || (nxt == CHAIN_END);
        if (cont && nxt != CHAIN_END) begin
          idx_q <= nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_valid_q <= 1'b0;
    end else if (out_load) begin
      seg_valid_q <= 1'b1;
    end else if (seg_o.ready) begin
      seg_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == S_ERR) begin
        seg_status_q <= STATUS_ERR;
        seg_lba_q    <= '0;
        seg_start_q  <= '0;
        seg_count_q  <= '0;
        seg_last_q   <= 1'b1;
      end else begin
        seg_status_q <= STATUS_OK;
        seg_lba_q    <= p_lba_q;
        seg_start_q  <= start32[8:0];
        seg_count_q  <= count32[9:0];
        seg_last_q   <= last_q;
      end
    end
  end

  assign seg_o.valid       = seg_valid_q;
  assign seg_o.status      = seg_status_q;
  assign seg_o.sector_addr = seg_lba_q;
  assign seg_o.byte_start  = seg_start_q;
  assign seg_o.byte_count  = seg_count_q;
  assign seg_o.last        = seg_last_q;

endmodule

// File: rtl/core/fcrm_checker.sv
module fcrm_checker
  import fcrm_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       req_cmd_i,
  input logic       seg_valid_i,
  input logic       seg_ready_i,
  input logic       seg_status_i,
  input logic [9:0] seg_count_i,
  input logic       seg_last_i
);

  // A stalled segment stays offered.
  a_seg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_i && !seg_ready_i |=> seg_valid_i)
    else $error("segment dropped while stalled");

  // A read request occupies the block on the following cycle.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_cmd_i == CMD_READ |=> !req_ready_i)
    else $error("ready right after a read request");

  // A load request completes at once.
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_cmd_i == CMD_LOAD |=> req_ready_i)
    else $error("not ready after a load request");

  // An error result is always the final, empty result.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_i && seg_status_i == STATUS_ERR |-> seg_last_i && seg_count_i == 10'd0)
    else $error("malformed error result");

endmodule

bind fat_chain_read_mapper_unit fcrm_checker u_fcrm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_cmd_i    (req_i.cmd),
  .seg_valid_i  (seg_o.valid),
  .seg_ready_i  (seg_o.ready),
  .seg_status_i (seg_o.status),
  .seg_count_i  (seg_o.byte_count),
  .seg_last_i   (seg_o.last)
);
